/* rtl/daft_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the device address filter table
package daft_pkg;

  localparam int ENTRIES   = 8;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ADDR_W    = 48;
  localparam int CMD_W     = 3;
  localparam int SLOT_OUT_W = 3;

  typedef enum logic [CMD_W-1:0] {
    OP_CLEAR   = 3'd0,
    OP_ADD     = 3'd1,
    OP_REMOVE  = 3'd2,
    OP_ENABLE  = 3'd3,
    OP_DISABLE = 3'd4,
    OP_MATCH   = 3'd5
  } op_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_APPLY = 1'b1
  } state_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              load;
    logic              apply;
    op_t               op_new;
    logic [ADDR_W-1:0] addr_new;
    logic              rnd_new;
    op_t               op_cur;
    logic [ADDR_W-1:0] addr_cur;
    logic              rnd_cur;
  } bcast_t;

  // low bits of a slot index, zero extended when the index is narrow
  function automatic logic [SLOT_OUT_W-1:0] slot_field(input logic [IDX_W-1:0] idx);
    logic [SLOT_OUT_W-1:0] res;
    res = '0;
    for (int b = 0; b < SLOT_OUT_W; b++) begin
      if (b < IDX_W) res[b] = idx[b];
    end
    return res;
  endfunction

endpackage

/* rtl/device_address_filter_table_unit.sv */
`timescale 1ns / 1ps
// top level: command sequencer, row of table cells and result register
// Device address filter table with ENTRIES slots of 48-bit address plus type.
// Input channel (in_valid/in_ready) takes one command word: command, address,
// address_random. Output channel (out_valid/out_ready) returns one result word
// per command: status (table full on add), matched and match_slot.
// Each command is accepted, then applied: in the accept cycle every cell
// compares the incoming address against its own entry and latches a
// candidate flag; in the apply cycle a priority token ripples through the
// row of cells, the lowest candidate acts, and the result is written to the
// output register, from which out_valid rises; a new word is taken only once
// the previous word has been applied over the cell row.
// The output register lets the next word be accepted while a result waits.
// If the receiver stalls with a result still held, the apply cycle waits.
// Reset clears all valid, type and enable bits; stored addresses are not
// cleared and are only read through a valid slot.
module device_address_filter_table_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [daft_pkg::CMD_W-1:0]   command,
  input  logic [daft_pkg::ADDR_W-1:0]  address,
  input  logic                         address_random,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         status,
  output logic                         matched,
  output logic [daft_pkg::SLOT_OUT_W-1:0] match_slot
);
  import daft_pkg::*;

  state_t            state;
  state_t            state_next;
  op_t               op;
  logic [ADDR_W-1:0] addr;
  logic              rnd;
  logic              load;
  logic              apply;
  bcast_t            bc;
  logic              taken [ENTRIES+1];
  logic [IDX_W-1:0]  slot  [ENTRIES+1];

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    in_ready   = 1'b0;
    apply      = 1'b0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        apply = !out_valid || out_ready;
        if (apply) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign load = in_valid && in_ready;

  // held command word
  always_ff @(posedge clk) begin
    if (load) begin
      op   <= op_t'(command);
      addr <= address;
      rnd  <= address_random;
    end
  end

  always_comb begin
    bc.load     = load;
    bc.apply    = apply;
    bc.op_new   = op_t'(command);
    bc.addr_new = address;
    bc.rnd_new  = address_random;
    bc.op_cur   = op;
    bc.addr_cur = addr;
    bc.rnd_cur  = rnd;
  end

  // row of cells, slot 0 first in the chain
  assign taken[0] = 1'b0;
  assign slot[0]  = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    daft_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .bc       (bc),
      .index    (IDX_W'(i)),
      .taken_in (taken[i]),
      .slot_in  (slot[i]),
      .taken_out(taken[i+1]),
      .slot_out (slot[i+1])
    );
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (apply) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      status     <= (op == OP_ADD) && !taken[ENTRIES];
      matched    <= (op == OP_MATCH) && taken[ENTRIES];
      match_slot <= ((op == OP_MATCH) && taken[ENTRIES]) ?
                    slot_field(slot[ENTRIES]) : '0;
    end
  end

`ifndef ASSERT_OFF
  a_one_per_item: assert property (@(posedge clk) disable iff (rst)
    load |=> (state == ST_APPLY) && !in_ready)
    else $error("accepted word did not enter apply");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY) && !apply |=> (state == ST_APPLY))
    else $error("apply left while result register busy");

  a_apply_fills: assert property (@(posedge clk) disable iff (rst)
    apply |=> out_valid)
    else $error("apply did not produce a result");

  a_excl_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(status && matched))
    else $error("status and matched both set");
`endif

endmodule

/* rtl/daft_cell.sv */
`timescale 1ns / 1ps
// one table slot: stored entry, candidate flag and priority chain link
module daft_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  daft_pkg::bcast_t              bc,
  input  logic [daft_pkg::IDX_W-1:0]    index,
  input  logic                          taken_in,
  input  logic [daft_pkg::IDX_W-1:0]    slot_in,
  output logic                          taken_out,
  output logic [daft_pkg::IDX_W-1:0]    slot_out
);
  import daft_pkg::*;

  logic [ADDR_W-1:0] addr;
  logic              rnd;
  logic              valid;
  logic              en;
  logic              cand;
  logic              eq;
  logic              cand_next;
  logic              sel;

  // compare against the incoming word
  assign eq = (addr == bc.addr_new) && (rnd == bc.rnd_new);

  always_comb begin
    case (bc.op_new)
      OP_ADD:    cand_next = !valid;
      OP_REMOVE: cand_next = valid && eq;
      OP_MATCH:  cand_next = en && eq;
      default:   cand_next = 1'b0;
    endcase
  end

  // lowest candidate wins, the token ripples up the row
  assign sel       = cand && !taken_in;
  assign taken_out = taken_in || cand;
  assign slot_out  = sel ? index : slot_in;

  // entry payload
  always_ff @(posedge clk) begin
    if (bc.apply && sel && (bc.op_cur == OP_ADD)) begin
      addr <= bc.addr_cur;
    end
  end

  // entry flags
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rnd   <= 1'b0;
      en    <= 1'b0;
      cand  <= 1'b0;
    end else begin
      if (bc.load) cand <= cand_next;
      if (bc.apply) begin
        case (bc.op_cur)
          OP_CLEAR: begin
            valid <= 1'b0;
            rnd   <= 1'b0;
            en    <= 1'b0;
          end
          OP_ADD: begin
            if (sel) begin
              valid <= 1'b1;
              rnd   <= bc.rnd_cur;
            end
          end
          OP_REMOVE: begin
            if (sel) begin
              valid <= 1'b0;
              en    <= 1'b0;
            end
          end
          OP_ENABLE:  en <= en || valid;
          OP_DISABLE: en <= 1'b0;
          default:    ;
        endcase
      end
    end
  end

endmodule
